@@ rtl/bdq_pkg.sv @@
// Shared types and codes for the bounded double-ended queue unit.
// Used by bdq_controller, bdq_datapath and bounded_double_ended_queue_unit.
package bdq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_LEFT  = 2'd0,
        ACT_PUSH_RIGHT = 2'd1,
        ACT_POP_LEFT   = 2'd2,
        ACT_POP_RIGHT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

    localparam logic       CFG_IDX_CAPACITY = 1'b0;
    localparam logic [4:0] CAPACITY_RESET   = 5'd16;

endpackage

@@ rtl/bdq_controller.sv @@
// Sequencing state machine for the deque: input acceptance and output register valid.
// Depends on bdq_pkg for the command struct.
module bdq_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bdq_pkg::t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load   = (r_state == S_LOAD) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (o_cmd.load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // An accepted word blocks the input until its result is loaded.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // A result is never loaded over one that is still held by a stall.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !o_cmd.load)
        else $error("output register overwritten while stalled");

    // Every load makes the output valid on the next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("load did not raise output valid");

endmodule

@@ rtl/bdq_datapath.sv @@
// Ring buffer storage, left end index, entry count and result register of the deque.
// Depends on bdq_pkg for action, status and command types.
module bdq_datapath #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdq_pkg::t_cmd      i_cmd,
    input  logic [4:0]         i_capacity,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_push_value,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [4:0]         o_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = (CW > 5) ? CW : 5;

    function automatic logic [IW-1:0] f_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        d = s - SW'(DEPTH);
        if (s >= SW'(DEPTH)) begin
            f_wrap = d[IW-1:0];
        end else begin
            f_wrap = s[IW-1:0];
        end
    endfunction

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [IW-1:0]          r_left;
    logic [CW-1:0]          r_count;
    bdq_pkg::t_status       r_pend_status;
    logic                   r_pend_pop;
    logic [VALUE_WIDTH-1:0] r_pend_val;
    bdq_pkg::t_status       r_status;
    logic [31:0]            r_value;
    logic [4:0]             r_occ;

    bdq_pkg::t_action       w_act;
    bdq_pkg::t_status       n_status;
    logic [IW-1:0]          n_left;
    logic [CW-1:0]          n_count;
    logic [IW-1:0]          w_pos;
    logic                   w_wr;
    logic                   w_rd;
    logic                   w_is_push;
    logic                   w_full;
    logic                   w_empty;
    logic [EW-1:0]          w_cap_ext;
    logic [EW-1:0]          w_eff_cap;
    logic [SW-1:0]          w_sum_right;
    logic [SW-1:0]          w_sum_last;
    logic [SW-1:0]          w_sum_inc;
    logic [IW-1:0]          w_left_dec;
    logic [VALUE_WIDTH+31:0] w_in_wide;
    logic [VALUE_WIDTH-1:0] w_in_val;
    logic [VALUE_WIDTH+31:0] w_rd_wide;
    logic [VALUE_WIDTH+31:0] w_pv_wide;
    logic [CW+4:0]          w_occ_wide;

    assign w_act       = bdq_pkg::t_action'(i_action);
    assign w_is_push   = (w_act == bdq_pkg::ACT_PUSH_LEFT) ||
                         (w_act == bdq_pkg::ACT_PUSH_RIGHT);
    assign w_cap_ext   = EW'(i_capacity);
    assign w_eff_cap   = (w_cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : w_cap_ext;
    assign w_full      = EW'(r_count) >= w_eff_cap;
    assign w_empty     = (r_count == '0);
    assign w_sum_right = SW'(r_left) + SW'(r_count);
    assign w_sum_last  = w_sum_right - SW'(1);
    assign w_sum_inc   = SW'(r_left) + SW'(1);
    assign w_left_dec  = (r_left == '0) ? IW'(DEPTH - 1) : r_left - IW'(1);
    assign w_in_wide   = {{VALUE_WIDTH{1'b0}}, i_push_value};
    assign w_in_val    = w_in_wide[VALUE_WIDTH-1:0];
    assign w_rd_wide   = {32'b0, r_rd_data};
    assign w_pv_wide   = {32'b0, r_pend_val};
    assign w_occ_wide  = {5'b0, r_count};

    always_comb begin
        n_status = bdq_pkg::ST_DONE;
        n_left   = r_left;
        n_count  = r_count;
        w_pos    = r_left;
        w_wr     = 1'b0;
        w_rd     = 1'b0;
        case (w_act)
            bdq_pkg::ACT_PUSH_LEFT: begin
                if (w_full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_left  = w_left_dec;
                    w_pos   = w_left_dec;
                    w_wr    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            bdq_pkg::ACT_PUSH_RIGHT: begin
                if (w_full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    w_pos   = f_wrap(w_sum_right);
                    w_wr    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            bdq_pkg::ACT_POP_LEFT: begin
                if (w_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    w_pos   = r_left;
                    w_rd    = 1'b1;
                    n_left  = f_wrap(w_sum_inc);
                    n_count = r_count - CW'(1);
                end
            end
            bdq_pkg::ACT_POP_RIGHT: begin
                if (w_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    w_pos   = f_wrap(w_sum_last);
                    w_rd    = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_status = bdq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_wr) begin
            r_mem[w_pos] <= w_in_val;
        end
        if (i_cmd.accept && w_rd) begin
            r_rd_data <= r_mem[w_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_status <= n_status;
            r_pend_pop    <= !w_is_push;
            r_pend_val    <= w_in_val;
        end
        if (i_cmd.load) begin
            r_status <= r_pend_status;
            r_occ    <= w_occ_wide[4:0];
            if (r_pend_status != bdq_pkg::ST_DONE) begin
                r_value <= '0;
            end else if (r_pend_pop) begin
                r_value <= w_rd_wide[31:0];
            end else begin
                r_value <= w_pv_wide[31:0];
            end
        end
    end

    assign o_status       = r_status;
    assign o_result_value = r_value;
    assign o_occupancy    = r_occ;

    // A refused action leaves the queue untouched.
    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && (n_status != bdq_pkg::ST_DONE)) |=>
        ($stable(r_count) && $stable(r_left)))
        else $error("refused action changed the queue");

    // A completed push adds exactly one entry.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && w_is_push && !w_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not add one entry");

    // The count never exceeds the storage and the left index stays in range.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_count) <= SW'(DEPTH)) && (SW'(r_left) < SW'(DEPTH)))
        else $error("queue index or count out of range");

endmodule

@@ rtl/bounded_double_ended_queue_unit.sv @@
// Bounded double-ended queue unit: capacity register, controller and datapath.
// An accepted input word is held in the pending and read-data registers, then loaded into the result register.
// The input stalls from acceptance until that result is loaded, and a load waits while a held result is stalled.
// Reset clears the queue (left index and count to zero) and sets capacity to 16.
// Entry memory contents are not cleared; no clearing pass is needed.
// Depends on bdq_pkg, bdq_controller and bdq_datapath.
module bounded_double_ended_queue_unit #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_push_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [4:0]         o_occupancy
);

    logic [4:0]    r_capacity;
    bdq_pkg::t_cmd w_cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bdq_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == bdq_pkg::CFG_IDX_CAPACITY)) begin
            r_capacity <= pwdata[4:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bdq_pkg::CFG_IDX_CAPACITY) begin
            prdata = {27'b0, r_capacity};
        end
    end

    bdq_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    bdq_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_capacity     (r_capacity),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_occupancy    (o_occupancy)
    );

endmodule
